FILE: hw/rtl/mseg_pkg.sv
`timescale 1ns / 1ps

package mseg_pkg;

  localparam int DEF_MAX_DIGIT_COUNT   = 8;
  localparam int DEF_MAX_SEGMENT_COUNT = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 40;
  localparam int PIN_MAP_W   = 40;
  localparam int DRIVE_W     = 24;
  localparam int OUT_DATA_W  = 40;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DIGIT_COUNT     = 3'd0,
    CFG_SEGMENT_COUNT   = 3'd1,
    CFG_REFRESH_PERIOD  = 3'd2,
    CFG_DIGIT_PIN_MAP   = 3'd3,
    CFG_SEGMENT_PIN_MAP = 3'd4
  } cfg_index_t;

  localparam logic [3:0]  RST_DIGIT_COUNT    = 4'd8;
  localparam logic [3:0]  RST_SEGMENT_COUNT  = 4'd8;
  localparam logic [15:0] RST_REFRESH_PERIOD = 16'd1000;

  localparam logic [7:0]  SPACE_CODE  = 8'h20;
  localparam logic [7:0]  DOT_CODE    = 8'h2E;
  localparam logic [7:0]  DOT_SEGMENT = 8'h80;
  localparam logic [15:0] TICK_MAX    = 16'hFFFF;
  localparam logic [4:0]  LAST_PIN    = 5'd23;

  // Segment patterns, bit 0 is segment A. Codes not listed light nothing.
  function automatic logic [7:0] seg_rom(input logic [7:0] ch);
    logic [7:0] segs;
    case (ch)
      8'h30: segs = 8'h3F;  8'h31: segs = 8'h06;  8'h32: segs = 8'h5B;
      8'h33: segs = 8'h4F;  8'h34: segs = 8'h66;  8'h35: segs = 8'h6D;
      8'h36: segs = 8'h7D;  8'h37: segs = 8'h07;  8'h38: segs = 8'h7F;
      8'h39: segs = 8'h6F;
      8'h41: segs = 8'h77;  8'h42: segs = 8'h7C;  8'h43: segs = 8'h39;
      8'h44: segs = 8'h5E;  8'h45: segs = 8'h79;  8'h46: segs = 8'h71;
      8'h47: segs = 8'h3D;  8'h48: segs = 8'h76;  8'h49: segs = 8'h30;
      8'h4A: segs = 8'h1E;  8'h4B: segs = 8'h76;  8'h4C: segs = 8'h38;
      8'h4D: segs = 8'h15;  8'h4E: segs = 8'h37;  8'h4F: segs = 8'h3F;
      8'h50: segs = 8'h73;  8'h51: segs = 8'h67;  8'h52: segs = 8'h33;
      8'h53: segs = 8'h6D;  8'h54: segs = 8'h78;  8'h55: segs = 8'h3E;
      8'h56: segs = 8'h1E;  8'h57: segs = 8'h2A;  8'h58: segs = 8'h76;
      8'h59: segs = 8'h6E;  8'h5A: segs = 8'h5B;
      8'h2D: segs = 8'h40;  8'h5F: segs = 8'h08;  8'h2E: segs = 8'h80;
      8'h3A: segs = 8'h48;  8'h3D: segs = 8'h48;  8'h21: segs = 8'h86;
      8'h3F: segs = 8'hD3;  8'h27: segs = 8'h02;  8'h22: segs = 8'h22;
      8'h3C: segs = 8'h70;  8'h3E: segs = 8'h43;  8'h5B: segs = 8'h39;
      8'h5D: segs = 8'h0F;  8'h2F: segs = 8'h52;  8'h5C: segs = 8'h64;
      default: segs = 8'h00;
    endcase
    return segs;
  endfunction

  // One-hot drive bit for the five-bit pin number in the given map slot; pins above 23 give no bit.
  function automatic logic [DRIVE_W-1:0] pin_bit(input logic [PIN_MAP_W-1:0] map,
                                                 input logic [2:0] slot);
    logic [4:0] pin;
    pin = map[5*slot +: 5];
    return (pin <= LAST_PIN) ? (24'd1 << pin) : '0;
  endfunction

endpackage

FILE: hw/rtl/multiplexed_segment_display_scan.sv
`timescale 1ns / 1ps
// A tick beat that completes a refresh period yields its output beat in the cycle after it is taken.
// Throughput: one input beat per cycle through a single registered pass to the output register;
// while a result waits there with out_tready low, no input beat is taken.
// Reset (synchronous, rst_n low): registers to their defaults, shown text all spaces without
// dots, staging, scan position and tick counter cleared, output empty.
module multiplexed_segment_display_scan #(
  parameter int MAX_DIGIT_COUNT   = mseg_pkg::DEF_MAX_DIGIT_COUNT,
  parameter int MAX_SEGMENT_COUNT = mseg_pkg::DEF_MAX_SEGMENT_COUNT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mseg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mseg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // char_code
  input  logic [1:0]                       in_tuser,   // command, text_first
  input  logic                             in_tlast,   // text_last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mseg_pkg::OUT_DATA_W-1:0]  out_tdata   // drive_word, digit_index,
                                                       // segment_bits, zero pad
);
  import mseg_pkg::*;

  localparam int DIGITS = (MAX_DIGIT_COUNT < 8) ? MAX_DIGIT_COUNT : 8;
  localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W  = $clog2(DIGITS + 1);

  logic [3:0]            digit_count_r;
  logic [3:0]            segment_count_r;
  logic [15:0]           refresh_period_r;
  logic [PIN_MAP_W-1:0]  digit_pin_map_r;
  logic [PIN_MAP_W-1:0]  segment_pin_map_r;

  logic [7:0]            staged_chars_r  [DIGITS];
  logic                  staged_dots_r   [DIGITS];
  logic [7:0]            staged_chars_nxt[DIGITS];
  logic                  staged_dots_nxt [DIGITS];
  logic [CNT_W-1:0]      staged_count_r, staged_count_nxt;
  logic                  dot_may_attach_r, dot_may_attach_nxt;
  logic                  text_ended_r, text_ended_nxt;

  logic [7:0]            shown_chars_r  [DIGITS];
  logic                  shown_dots_r   [DIGITS];
  logic [7:0]            shown_chars_nxt[DIGITS];
  logic                  shown_dots_nxt [DIGITS];

  logic [IDX_W-1:0]      scan_digit_r, scan_digit_nxt;
  logic [15:0]           tick_count_r, tick_count_nxt;

  logic                  out_valid_r;
  logic [DRIVE_W-1:0]    drive_word_r, drive_word_nxt;
  logic [2:0]            digit_index_r;
  logic [7:0]            segment_bits_r, segment_bits_nxt;

  logic                  in_beat, char_beat, tick_beat, commit;
  logic [3:0]            digits_used, segs_used;
  logic [CNT_W-1:0]      cnt_dec;
  logic [7:0]            code_up;
  logic [IDX_W-1:0]      scan_sel;
  logic [3:0]            scan_inc;
  logic [15:0]           tick_inc;
  logic                  scan_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign char_beat = in_beat && in_tuser[0];
  assign tick_beat = in_beat && !in_tuser[0];
  assign commit    = in_beat && in_tlast;

  always_comb begin
    if (digit_count_r == 4'd0) begin
      digits_used = 4'd1;
    end else if (digit_count_r > 4'(DIGITS)) begin
      digits_used = 4'(DIGITS);
    end else begin
      digits_used = digit_count_r;
    end
    segs_used = (segment_count_r > 4'(MAX_SEGMENT_COUNT)) ? 4'(MAX_SEGMENT_COUNT)
                                                           : segment_count_r;
  end

  // Text staging followed by an optional commit into the shown buffer.
  always_comb begin
    logic [3:0] src;
    staged_chars_nxt   = staged_chars_r;
    staged_dots_nxt    = staged_dots_r;
    staged_count_nxt   = staged_count_r;
    dot_may_attach_nxt = dot_may_attach_r;
    text_ended_nxt     = text_ended_r;
    code_up            = in_tdata;
    if (in_tdata inside {[8'h61:8'h7A]}) begin
      code_up = in_tdata - 8'h20;
    end
    if (char_beat && in_tuser[1]) begin
      staged_count_nxt   = '0;
      dot_may_attach_nxt = 1'b0;
      text_ended_nxt     = 1'b0;
    end
    cnt_dec = staged_count_nxt - 1'b1;
    if (char_beat && !text_ended_nxt) begin
      if (in_tdata == 8'h00) begin
        text_ended_nxt = 1'b1;
      end else if (in_tdata == DOT_CODE && dot_may_attach_nxt && staged_count_nxt != '0) begin
        staged_dots_nxt[cnt_dec[IDX_W-1:0]] = 1'b1;
        dot_may_attach_nxt = 1'b0;
      end else if (4'(staged_count_nxt) >= digits_used) begin
        text_ended_nxt = 1'b1;
      end else begin
        staged_chars_nxt[staged_count_nxt[IDX_W-1:0]] = code_up;
        staged_dots_nxt[staged_count_nxt[IDX_W-1:0]]  = 1'b0;
        staged_count_nxt   = staged_count_nxt + 1'b1;
        dot_may_attach_nxt = 1'b1;
      end
    end

    // On a commit, digit i shows staged position digits_used-1-i; unused digits and positions are blank.
    shown_chars_nxt = shown_chars_r;
    shown_dots_nxt  = shown_dots_r;
    for (int i = 0; i < DIGITS; i++) begin
      src = digits_used - 4'd1 - 4'(i);
      if (commit) begin
        shown_chars_nxt[i] = SPACE_CODE;
        shown_dots_nxt[i]  = 1'b0;
        if (4'(i) < digits_used && src < 4'(staged_count_nxt)) begin
          shown_chars_nxt[i] = staged_chars_nxt[src[IDX_W-1:0]];
          shown_dots_nxt[i]  = staged_dots_nxt[src[IDX_W-1:0]];
        end
      end
    end
  end

  // Tick counting and the scan step for the current digit.
  always_comb begin
    logic [7:0] segs;
    scan_sel = (4'(scan_digit_r) < digits_used) ? scan_digit_r : '0;
    scan_inc = 4'(scan_sel) + 4'd1;
    tick_inc = (tick_count_r != TICK_MAX) ? tick_count_r + 16'd1 : tick_count_r;
    scan_fire = tick_beat && (tick_inc >= refresh_period_r);

    segs = seg_rom(shown_chars_r[scan_sel]);
    if (shown_dots_r[scan_sel]) begin
      segs = segs | DOT_SEGMENT;
    end
    drive_word_nxt = pin_bit(digit_pin_map_r, 3'(scan_sel));
    for (int s = 0; s < 8; s++) begin
      segment_bits_nxt[s] = segs[s] && (4'(s) < segs_used);
      if (segment_bits_nxt[s]) begin
        drive_word_nxt = drive_word_nxt | pin_bit(segment_pin_map_r, 3'(s));
      end
    end

    tick_count_nxt = tick_count_r;
    scan_digit_nxt = scan_digit_r;
    if (tick_beat) begin
      tick_count_nxt = tick_inc;
      if (scan_fire) begin
        tick_count_nxt = '0;
        scan_digit_nxt = (scan_inc == digits_used) ? '0 : scan_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r     <= RST_DIGIT_COUNT;
      segment_count_r   <= RST_SEGMENT_COUNT;
      refresh_period_r  <= RST_REFRESH_PERIOD;
      digit_pin_map_r   <= '0;
      segment_pin_map_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIGIT_COUNT:     digit_count_r     <= cfg_data[3:0];
        CFG_SEGMENT_COUNT:   segment_count_r   <= cfg_data[3:0];
        CFG_REFRESH_PERIOD:  refresh_period_r  <= cfg_data[15:0];
        CFG_DIGIT_PIN_MAP:   digit_pin_map_r   <= cfg_data[PIN_MAP_W-1:0];
        CFG_SEGMENT_PIN_MAP: segment_pin_map_r <= cfg_data[PIN_MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    staged_chars_r <= staged_chars_nxt;
    staged_dots_r  <= staged_dots_nxt;
    if (scan_fire) begin
      drive_word_r   <= drive_word_nxt;
      digit_index_r  <= 3'(scan_sel);
      segment_bits_r <= segment_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      staged_count_r   <= '0;
      dot_may_attach_r <= 1'b0;
      text_ended_r     <= 1'b0;
      scan_digit_r     <= '0;
      tick_count_r     <= '0;
      out_valid_r      <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        shown_chars_r[i] <= SPACE_CODE;
        shown_dots_r[i]  <= 1'b0;
      end
    end else begin
      staged_count_r   <= staged_count_nxt;
      dot_may_attach_r <= dot_may_attach_nxt;
      text_ended_r     <= text_ended_nxt;
      scan_digit_r     <= scan_digit_nxt;
      tick_count_r     <= tick_count_nxt;
      shown_chars_r    <= shown_chars_nxt;
      shown_dots_r     <= shown_dots_nxt;
      // A beat is only taken when the output register is empty or draining.
      if (in_beat) begin
        out_valid_r <= scan_fire;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, segment_bits_r, digit_index_r, drive_word_r};

endmodule

FILE: tb/tb_multiplexed_segment_display_scan.sv
`timescale 1ns / 1ps

module tb_multiplexed_segment_display_scan;
  import mseg_pkg::*;

  localparam int PHASES       = 10;
  localparam int PHASE_BEATS  = 140;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum bit {CMD_TICK = 1'b0, CMD_CHAR = 1'b1} beat_kind_t;

  typedef struct packed {
    logic [23:0] drive;
    logic [2:0]  digit;
    logic [7:0]  segs;
  } scan_result_t;

  typedef struct packed {
    beat_kind_t   kind;
    logic [7:0]   code;
    bit           first;
    bit           last;
    bit           fixed;
    scan_result_t res;
  } dir_row_t;

  localparam scan_result_t BLANK0 = '{24'h000001, 3'd0, 8'h00};
  localparam scan_result_t BLANK1 = '{24'h000001, 3'd1, 8'h00};
  localparam scan_result_t BLANK2 = '{24'h000001, 3'd2, 8'h00};

  // Runs with the reset pin maps (every line on output 0) and a refresh period of one tick.
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b1, BLANK0},
    '{CMD_TICK, 8'hFF, 1'b1, 1'b0, 1'b1, BLANK1},
    '{CMD_CHAR, 8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h2E, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h2E, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h7A, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h7F, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h38, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_TICK, 8'h55, 1'b0, 1'b1, 1'b1, BLANK2},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h30, 1'b1, 1'b1, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_CHAR, 8'h2E, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h2E, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_CHAR, 8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, '0}
  };

  localparam logic [7:0] NUMERAL_SEGS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [7:0] LETTER_SEGS [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30, 8'h1E, 8'h76, 8'h38, 8'h15,
    8'h37, 8'h3F, 8'h73, 8'h67, 8'h33, 8'h6D, 8'h78, 8'h3E, 8'h1E, 8'h2A, 8'h76, 8'h6E, 8'h5B
  };
  localparam logic [7:0] PUNCT_CODES [15] = '{
    8'h2D, 8'h5F, 8'h2E, 8'h3A, 8'h3D, 8'h21, 8'h3F, 8'h27,
    8'h22, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h2F, 8'h5C
  };
  localparam logic [7:0] PUNCT_SEGS [15] = '{
    8'h40, 8'h08, 8'h80, 8'h48, 8'h48, 8'h86, 8'hD3, 8'h02,
    8'h22, 8'h70, 8'h43, 8'h39, 8'h0F, 8'h52, 8'h64
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;   // char_code
  logic [1:0]             in_tuser;   // command, text_first
  logic                   in_tlast;   // text_last
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;  // drive_word, digit_index, segment_bits, zero pad

  multiplexed_segment_display_scan DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Register copies and display state kept by the predictor.
  logic [3:0]  reg_digits;
  logic [3:0]  reg_segments;
  logic [15:0] reg_period;
  logic [39:0] reg_digit_pins;
  logic [39:0] reg_segment_pins;

  logic [7:0] glyph [256];
  logic [7:0] staged_ch [8];
  bit         staged_dot [8];
  int         staged_n;
  bit         dot_ok;
  bit         text_done;
  logic [7:0] shown_ch [8];
  bit         shown_dot [8];
  int         scan_pos;
  int         ticks;

  scan_result_t expected_scans [$];
  int           errors;
  int           cycles;
  int           beats_taken;
  int           scans_checked;
  int           settings_used;
  bit           idle_on;
  bit           beat_fixed;
  scan_result_t beat_fixed_res;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d scans outstanding.", cycles,
               expected_scans.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bit calm();
    return ((cycles / 256) % 4) == 1;
  endfunction

  function automatic int digits_used();
    int n = reg_digits;
    if (n == 0) n = 1;
    if (n > 8) n = 8;
    return n;
  endfunction

  function automatic logic [23:0] pin_drive(input logic [39:0] map, input int slot);
    logic [4:0] pin;
    pin = 5'(map >> (5 * slot));
    if (pin > 5'd23) return '0;
    return 24'd1 << pin;
  endfunction

  function automatic void stage_char(input logic [7:0] code, input bit first);
    logic [7:0] c;
    int         n;
    c = code;
    n = digits_used();
    if (first) begin
      staged_n  = 0;
      dot_ok    = 1'b0;
      text_done = 1'b0;
    end
    if (text_done) return;
    if (c == 8'h00) begin
      text_done = 1'b1;
      return;
    end
    if (c == DOT_CODE && dot_ok && staged_n > 0) begin
      staged_dot[staged_n-1] = 1'b1;
      dot_ok = 1'b0;
      return;
    end
    if (staged_n >= n) begin
      text_done = 1'b1;
      return;
    end
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    staged_ch[staged_n]  = c;
    staged_dot[staged_n] = 1'b0;
    staged_n++;
    dot_ok = 1'b1;
  endfunction

  // Position 0 of the staged text lands on the highest digit in use.
  function automatic void commit_text();
    int n;
    int src;
    n = digits_used();
    for (int i = 0; i < 8; i++) begin
      shown_ch[i]  = SPACE_CODE;
      shown_dot[i] = 1'b0;
      src = n - 1 - i;
      if (i < n && src < staged_n) begin
        shown_ch[i]  = staged_ch[src];
        shown_dot[i] = staged_dot[src];
      end
    end
  endfunction

  function automatic scan_result_t scan_digit_out();
    scan_result_t r;
    int           n;
    int           ns;
    int           d;
    logic [7:0]   segs;
    n  = digits_used();
    ns = (reg_segments > 8) ? 8 : int'(reg_segments);
    d  = (scan_pos < n) ? scan_pos : 0;
    segs = glyph[shown_ch[d]];
    if (shown_dot[d]) segs = segs | DOT_SEGMENT;
    segs = segs & 8'((9'd1 << ns) - 9'd1);
    r.drive = pin_drive(reg_digit_pins, d);
    for (int s = 0; s < ns; s++)
      if (segs[s]) r.drive = r.drive | pin_drive(reg_segment_pins, s);
    r.digit = 3'(d);
    r.segs  = segs;
    scan_pos = (d + 1) % n;
    return r;
  endfunction

  // A tick is handled before a commit carried on the same beat.
  function automatic bit scan_predict(input beat_kind_t kind, input logic [7:0] code,
                                      input bit first, input bit last,
                                      output scan_result_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    if (kind == CMD_CHAR) begin
      stage_char(code, first);
    end else begin
      if (ticks < 65535) ticks++;
      if (ticks >= reg_period) begin
        ticks = 0;
        r     = scan_digit_out();
        hit   = 1'b1;
      end
    end
    if (last) commit_text();
    return hit;
  endfunction

  always @(posedge clk) begin : score
    scan_result_t got;
    scan_result_t want;
    scan_result_t calc;
    bit           hit;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.drive = out_tdata[23:0];
        got.digit = out_tdata[26:24];
        got.segs  = out_tdata[34:27];
        scans_checked++;
        if (expected_scans.size() == 0) begin
          $error("Unexpected scan beat: drive_word %h digit_index %0d segment_bits %h",
                 got.drive, got.digit, got.segs);
          errors++;
        end else begin
          want = expected_scans.pop_front();
          if (got.drive !== want.drive) begin
            $error("drive_word mismatch: expected %h, got %h", want.drive, got.drive);
            errors++;
          end
          if (got.digit !== want.digit) begin
            $error("digit_index mismatch: expected %0d, got %0d", want.digit, got.digit);
            errors++;
          end
          if (got.segs !== want.segs) begin
            $error("segment_bits mismatch: expected %h, got %h", want.segs, got.segs);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        beats_taken++;
        hit = scan_predict(beat_kind_t'(in_tuser[0]), in_tdata, in_tuser[1], in_tlast, calc);
        if (hit) expected_scans.push_back(beat_fixed ? beat_fixed_res : calc);
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && !calm() && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_beat(input beat_kind_t kind, input logic [7:0] code, input bit first,
                           input bit last, input bit fixed = 1'b0,
                           input scan_result_t res = '0);
    if (idle_on && !calm() && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    beat_fixed     = fixed;
    beat_fixed_res = res;
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tuser  <= {first, kind};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int count);
    repeat (count)
      send_beat(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 15) == 0);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 7))
      0:       return 8'h61 + 8'($urandom_range(0, 25));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      2:       return 8'h30 + 8'($urandom_range(0, 9));
      3, 4:    return DOT_CODE;
      5:       return PUNCT_CODES[$urandom_range(0, 14)];
      6:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // A whole text with ticks mixed in, sometimes ended by a zero code, committed on its last beat.
  task automatic send_text();
    int len;
    len = $urandom_range(0, 10);
    send_beat(CMD_CHAR, pick_char(), 1'b1, 1'b0);
    repeat (len) begin
      if ($urandom_range(0, 1)) send_ticks($urandom_range(1, 3));
      send_beat(CMD_CHAR, pick_char(), 1'b0, 1'b0);
    end
    if ($urandom_range(0, 2) == 0) send_beat(CMD_CHAR, 8'h00, 1'b0, 1'b0);
    if ($urandom_range(0, 1))
      send_beat(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    else
      send_beat(CMD_CHAR, pick_char(), 1'b0, 1'b1);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_scans.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [39:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIGIT_COUNT:     reg_digits       = value[3:0];
      CFG_SEGMENT_COUNT:   reg_segments     = value[3:0];
      CFG_REFRESH_PERIOD:  reg_period       = value[15:0];
      CFG_DIGIT_PIN_MAP:   reg_digit_pins   = value;
      CFG_SEGMENT_PIN_MAP: reg_segment_pins = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] digits, input logic [3:0] segments,
                            input logic [15:0] period, input logic [39:0] dpins,
                            input logic [39:0] spins);
    write_reg(CFG_DIGIT_COUNT, 40'(digits));
    write_reg(CFG_SEGMENT_COUNT, 40'(segments));
    write_reg(CFG_REFRESH_PERIOD, 40'(period));
    write_reg(CFG_DIGIT_PIN_MAP, dpins);
    write_reg(CFG_SEGMENT_PIN_MAP, spins);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [39:0] random_pins();
    return 40'({$urandom(), $urandom()});
  endfunction

  initial begin
    int start;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    errors     = 0;
    cycles     = 0;
    beats_taken   = 0;
    scans_checked = 0;
    settings_used = 0;
    idle_on       = 1'b1;
    beat_fixed    = 1'b0;

    reg_digits       = RST_DIGIT_COUNT;
    reg_segments     = RST_SEGMENT_COUNT;
    reg_period       = RST_REFRESH_PERIOD;
    reg_digit_pins   = '0;
    reg_segment_pins = '0;
    for (int i = 0; i < 256; i++) glyph[i] = 8'h00;
    for (int i = 0; i < 10; i++) glyph[8'h30 + i] = NUMERAL_SEGS[i];
    for (int i = 0; i < 26; i++) glyph[8'h41 + i] = LETTER_SEGS[i];
    for (int i = 0; i < 15; i++) glyph[PUNCT_CODES[i]] = PUNCT_SEGS[i];
    for (int i = 0; i < 8; i++) begin
      staged_ch[i]  = 8'h00;
      staged_dot[i] = 1'b0;
      shown_ch[i]   = SPACE_CODE;
      shown_dot[i]  = 1'b0;
    end
    staged_n  = 0;
    dot_ok    = 1'b0;
    text_done = 1'b0;
    scan_pos  = 0;
    ticks     = 0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(CFG_REFRESH_PERIOD, 40'd1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(DIRECTED[i].kind, DIRECTED[i].code, DIRECTED[i].first, DIRECTED[i].last,
                DIRECTED[i].fixed, DIRECTED[i].res);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_config(4'd8, 4'd8, 16'd1, random_pins(), random_pins());
        1:       set_config(4'd1, 4'd0, 16'd2, 40'd0, 40'hFF_FFFF_FFFF);
        2:       set_config(4'd0, 4'd15, 16'd0, random_pins(), random_pins());
        3:       set_config(4'd15, 4'd9, 16'd3, random_pins(), random_pins());
        // The counter keeps climbing here; the next setting then fires on its first tick.
        4:       set_config(4'd4, 4'd7, 16'd65535, random_pins(), random_pins());
        5:       set_config(4'd3, 4'd8, 16'd1, random_pins(), random_pins());
        default: set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            16'($urandom_range(1, 6)), random_pins(), random_pins());
      endcase
      if (p == PHASES - 1) idle_on = 1'b0;
      start = beats_taken;
      while (beats_taken - start < PHASE_BEATS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_text();
          6, 7:             send_ticks($urandom_range(1, 6));
          default:          send_beat(beat_kind_t'($urandom_range(0, 1)),
                                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                      $urandom_range(0, 3) == 0);
        endcase
      end
      wait_idle();
    end

    repeat (16) @(negedge clk);
    if (expected_scans.size() != 0) begin
      $error("%0d expected scan beats never arrived", expected_scans.size());
      errors++;
    end
    $display("Sent %0d text and tick beats under %0d register settings.", beats_taken,
             settings_used);
    $display("Checked %0d scan beats; %0d field mismatches seen.", scans_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mseg_pkg.sv
hw/rtl/multiplexed_segment_display_scan.sv
tb/tb_multiplexed_segment_display_scan.sv
